[rtl/msort_pkg.sv]
// ============================================================================
// msort_pkg: shared types and constants of the merge sort engine
// Data width, default capacity and the controller state encoding.
// ============================================================================
package msort_pkg;

	// Width of one element and of the stream data word
	localparam int unsigned DATA_W = 32;

	// Default capacity of the element store
	localparam int unsigned MAX_ITEMS_DEF = 64;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		ST_LOAD     = 5'b00001,
		ST_MERGE_RD = 5'b00010,
		ST_MERGE_WR = 5'b00100,
		ST_OUT_RD   = 5'b01000,
		ST_OUT_SEND = 5'b10000
	} state_t;

endpackage

[rtl/msort_ram.sv]
// ============================================================================
// msort_ram: element buffer with one write port and two read ports
// Synchronous memory; read data appears in the cycle after a read enable and
// holds until the next read.
// ============================================================================
module msort_ram #(
	parameter int unsigned DEPTH  = msort_pkg::MAX_ITEMS_DEF,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [msort_pkg::DATA_W-1:0]  wdata,
	input  logic                          re,
	input  logic [ADDR_W-1:0]             raddr_a,
	input  logic [ADDR_W-1:0]             raddr_b,
	output logic [msort_pkg::DATA_W-1:0]  rdata_a,
	output logic [msort_pkg::DATA_W-1:0]  rdata_b
);

	logic [msort_pkg::DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[rtl/merge_sort_engine.sv]
// ============================================================================
// merge_sort_engine: stable ascending sort of a set of signed 32-bit values
// Collects values into a buffer until a transfer with tlast closes the set,
// sorts it by bottom-up merge passes between two buffers, then streams the
// sorted values out with tlast on the final one.
// ============================================================================
//
// Channel  | Direction | tdata              | tlast           | tuser
// ---------+-----------+--------------------+-----------------+---------------
// s_*      | in        | [31:0] value       | last of the set | -
// m_*      | out       | [31:0] sorted_value| final_res       | [0] overflow
//
// Loading accepts one value per cycle. Each merge pass handles each
// element in two steps (read both run heads, then compare and write), and a
// set of n values needs ceil(log2(n)) passes. Each result is read from the
// buffer and then sent, and m_tready can hold it off. No new value is taken
// while a set is being sorted or sent. The buffers need no clearing after
// reset.
//
module merge_sort_engine #(
	parameter int unsigned MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [msort_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
	input  logic                          s_tlast,   // last
	// Output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [msort_pkg::DATA_W-1:0]  m_tdata,   // [31:0] sorted_value
	output logic                          m_tlast,   // final_res
	output logic                          m_tuser    // [0] overflow
);

	localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
	localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int unsigned W_W    = CNT_W + 1;
	localparam int unsigned SUM_W  = CNT_W + 2;

	msort_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             drop_q, drop_d;
	logic             sel_q, sel_d;       // 0: sorted data in buffer A
	logic [W_W-1:0]   width_q, width_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] mid_q, mid_d;
	logic [CNT_W-1:0] hi_q, hi_d;

	logic                         in_xfer;
	logic                         has_room;
	logic [CNT_W-1:0]             cnt_inc;
	logic [W_W-1:0]               width2;
	logic [CNT_W-1:0]             k_inc;

	logic [CNT_W-1:0]             run_lo;
	logic [W_W-1:0]               run_w;
	logic [CNT_W-1:0]             run_n;
	logic [SUM_W-1:0]             mid_sum;
	logic [SUM_W-1:0]             hi_sum;
	logic [CNT_W-1:0]             run_mid;
	logic [CNT_W-1:0]             run_hi;

	logic                         rd_en;
	logic                         a_we, b_we;
	logic [ADDR_W-1:0]            wr_addr;
	logic [msort_pkg::DATA_W-1:0] wr_data;
	logic [ADDR_W-1:0]            rd_addr_a, rd_addr_b;
	logic [msort_pkg::DATA_W-1:0] a_rd_a, a_rd_b, b_rd_a, b_rd_b;
	logic [msort_pkg::DATA_W-1:0] head_l, head_r;
	logic                         take_left;

	// Handshake and small helpers
	assign in_xfer  = s_tvalid && s_tready;
	assign has_room = (cnt_q < CNT_W'(MAX_ITEMS));
	assign cnt_inc  = has_room ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign width2   = {width_q[W_W-2:0], 1'b0};
	assign k_inc    = k_q + CNT_W'(1);

	// Head values of the left and right runs come from the source buffer.
	assign head_l    = sel_q ? b_rd_a : a_rd_a;
	assign head_r    = sel_q ? b_rd_b : a_rd_b;
	assign take_left = (i_q < mid_q) &&
	                   ((j_q >= hi_q) || ($signed(head_l) <= $signed(head_r)));

	// Bounds of the next run: the set length, start and width are chosen by
	// context so the same clamp logic serves every place a run starts.
	always_comb begin
		run_lo = '0;
		run_w  = W_W'(1);
		run_n  = cnt_inc;
		if (state_q == msort_pkg::ST_MERGE_WR) begin
			run_n = cnt_q;
			if (hi_q == cnt_q) begin
				run_w = width2;
			end else begin
				run_lo = hi_q;
				run_w  = width_q;
			end
		end
	end

	assign mid_sum = SUM_W'(run_lo) + SUM_W'(run_w);
	assign hi_sum  = SUM_W'(run_lo) + {run_w, 1'b0};
	assign run_mid = (mid_sum > SUM_W'(run_n)) ? run_n : mid_sum[CNT_W-1:0];
	assign run_hi  = (hi_sum > SUM_W'(run_n)) ? run_n : hi_sum[CNT_W-1:0];

	// Controller next state, memory addresses and write enables
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		drop_d    = drop_q;
		sel_d     = sel_q;
		width_d   = width_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		mid_d     = mid_q;
		hi_d      = hi_q;
		rd_en     = 1'b0;
		rd_addr_a = i_q[ADDR_W-1:0];
		rd_addr_b = j_q[ADDR_W-1:0];
		a_we      = 1'b0;
		b_we      = 1'b0;
		wr_addr   = k_q[ADDR_W-1:0];
		wr_data   = head_r;

		case (state_q)
			msort_pkg::ST_LOAD: begin
				if (in_xfer) begin
					if (has_room) begin
						a_we    = 1'b1;
						wr_addr = cnt_q[ADDR_W-1:0];
						wr_data = s_tdata;
						cnt_d   = cnt_inc;
					end else begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						sel_d   = 1'b0;
						width_d = W_W'(1);
						i_d     = '0;
						j_d     = run_mid;
						mid_d   = run_mid;
						hi_d    = run_hi;
						k_d     = '0;
						state_d = (cnt_inc > CNT_W'(1)) ? msort_pkg::ST_MERGE_RD
						                                : msort_pkg::ST_OUT_RD;
					end
				end
			end

			msort_pkg::ST_MERGE_RD: begin
				rd_en   = 1'b1;
				state_d = msort_pkg::ST_MERGE_WR;
			end

			msort_pkg::ST_MERGE_WR: begin
				// Ties go to the left run, which keeps the sort stable.
				wr_data = take_left ? head_l : head_r;
				a_we    = sel_q;
				b_we    = !sel_q;
				if (take_left) begin
					i_d = i_q + CNT_W'(1);
				end else begin
					j_d = j_q + CNT_W'(1);
				end
				k_d     = k_inc;
				state_d = msort_pkg::ST_MERGE_RD;
				if (k_inc == hi_q) begin
					if (hi_q == cnt_q) begin
						// Pass complete: the destination becomes the source.
						sel_d   = !sel_q;
						width_d = width2;
						k_d     = '0;
						if (width2 >= W_W'(cnt_q)) begin
							state_d = msort_pkg::ST_OUT_RD;
						end else begin
							i_d   = '0;
							j_d   = run_mid;
							mid_d = run_mid;
							hi_d  = run_hi;
						end
					end else begin
						// Next pair of runs in the same pass
						i_d   = hi_q;
						j_d   = run_mid;
						mid_d = run_mid;
						hi_d  = run_hi;
					end
				end
			end

			msort_pkg::ST_OUT_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = k_q[ADDR_W-1:0];
				state_d   = msort_pkg::ST_OUT_SEND;
			end

			msort_pkg::ST_OUT_SEND: begin
				if (m_tready) begin
					if (m_tlast) begin
						cnt_d   = '0;
						drop_d  = 1'b0;
						state_d = msort_pkg::ST_LOAD;
					end else begin
						k_d     = k_inc;
						state_d = msort_pkg::ST_OUT_RD;
					end
				end
			end

			default: begin
				state_d = msort_pkg::ST_LOAD;
			end
		endcase
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msort_pkg::ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			sel_q   <= 1'b0;
			width_q <= W_W'(1);
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			sel_q   <= sel_d;
			width_q <= width_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
		end
	end

	// Buffer A holds the loaded set; A and B alternate as merge source.
	msort_ram #(
		.DEPTH (MAX_ITEMS)
	) u_ram_a (
		.clk     (clk),
		.we      (a_we),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.re      (rd_en),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (a_rd_a),
		.rdata_b (a_rd_b)
	);

	msort_ram #(
		.DEPTH (MAX_ITEMS)
	) u_ram_b (
		.clk     (clk),
		.we      (b_we),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.re      (rd_en),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (b_rd_a),
		.rdata_b (b_rd_b)
	);

	// Stream ports
	assign s_tready = (state_q == msort_pkg::ST_LOAD);
	assign m_tvalid = (state_q == msort_pkg::ST_OUT_SEND);
	assign m_tdata  = head_l;
	assign m_tlast  = (k_inc == cnt_q);
	assign m_tuser  = drop_q;

	// Input and output sides are never open at once.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open in the same cycle");

	// A merge write always lands inside the current run pair.
	a_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msort_pkg::ST_MERGE_WR) |-> (k_q < hi_q) && (hi_q <= cnt_q))
		else $error("merge write outside the run");

	// Run heads never pass their run ends.
	a_heads_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msort_pkg::ST_MERGE_WR) |-> (i_q <= mid_q) && (j_q <= hi_q)
		&& (mid_q <= hi_q))
		else $error("run head beyond run end");

	// After the final result the block is empty and ready for a new set.
	a_clear_after_set: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready && (cnt_q == '0) && !drop_q)
		else $error("set not cleared after final result");

endmodule
